// File: rtl/gms_pkg.sv
// Package with the mode codes, goal codes, constants and payload types of the gripper sequencer.
`timescale 1ns / 1ps

package gms_pkg;

  localparam int COUNT_W = 11;
  localparam int TICKS_W = 10;
  localparam int MODE_W  = 3;

  localparam logic [MODE_W-1:0] MODE_IDLE      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INTAKING  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CARRYING  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_OUTTAKING = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PREPPING  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_HANDOFF   = 3'd5;

  localparam logic [2:0] GOAL_NONE    = 3'd0;
  localparam logic [2:0] GOAL_INTAKE  = 3'd1;
  localparam logic [2:0] GOAL_HOLD    = 3'd2;
  localparam logic [2:0] GOAL_SCORE   = 3'd3;
  localparam logic [2:0] GOAL_PREP    = 3'd4;
  localparam logic [2:0] GOAL_HANDOFF = 3'd5;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_GOAL = 1'b1;

  localparam logic CFG_SCORE_TICKS   = 1'b0;
  localparam logic CFG_RELEASE_TICKS = 1'b1;

  localparam logic [TICKS_W-1:0] SCORE_TICKS_RESET   = 10'd20;
  localparam logic [TICKS_W-1:0] RELEASE_TICKS_RESET = 10'd50;
  localparam logic [COUNT_W-1:0] PULSE_TICKS         = 11'd10;
  localparam logic [COUNT_W-1:0] COUNT_MAX           = 11'd2047;

  typedef struct packed {
    logic       kind;
    logic [2:0] goal_code;
    logic       force_release;
    logic       proximity;
    logic       drive_enabled;
  } in_item_t;

  typedef struct packed {
    logic              flute_out;
    logic              backplate_out;
    logic              holding_item;
    logic [MODE_W-1:0] mode_code;
  } out_item_t;

endpackage

// File: rtl/gripper_mode_sequencer_unit.sv
// Top level of the gripper mode sequencer: mode logic, shared counter and output buffer.
`timescale 1ns / 1ps

// The block takes one item per clock cycle while its second buffer entry is empty. A goal
// command updates the mode and the force-release flag (a score goal also clears the
// counter) and gives no result; a tick gives one registered result. The mode, counter and
// has-item state update in the transfer cycle through a single pass of logic; results leave
// through a two-entry output buffer, so transfers go on while one result waits for the consumer.
module gripper_mode_sequencer_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  gms_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output gms_pkg::out_item_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [9:0]        cfg_data
);
  import gms_pkg::*;

  logic [TICKS_W-1:0] score_ticks;
  logic [TICKS_W-1:0] release_ticks;
  logic [MODE_W-1:0]  mode;
  logic [MODE_W-1:0]  mode_next;
  logic [COUNT_W-1:0] tick_count;
  logic [COUNT_W-1:0] tick_count_next;
  logic               item_flag;
  logic               item_flag_next;
  logic               release_forced;
  logic               skid_valid;
  out_item_t          skid_data;
  out_item_t          result;
  logic               take;
  logic               push;
  logic [COUNT_W-1:0] count_a;
  logic [COUNT_W-1:0] count_b;
  logic [MODE_W-1:0]  mode_a;
  logic               flute;
  logic               back;

  function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] c);
    count_up = (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

  assign in_ready = !skid_valid;
  assign take     = in_valid && in_ready;
  assign push     = take && (in_data.kind == KIND_TICK);

  always_comb begin
    flute   = 1'b0;
    back    = 1'b0;
    mode_a  = mode;
    count_a = tick_count;
    case (mode)
      MODE_IDLE: begin
        flute = 1'b1;
        back  = in_data.proximity;
        if (in_data.proximity) mode_a = MODE_CARRYING;
      end
      MODE_INTAKING: begin
        flute = 1'b1;
        back  = !in_data.proximity;
        if (in_data.proximity) mode_a = MODE_CARRYING;
      end
      MODE_CARRYING: begin
        flute = 1'b1;
      end
      MODE_OUTTAKING: begin
        back    = tick_count < PULSE_TICKS;
        count_a = count_up(tick_count);
        if (count_a > {1'b0, score_ticks}) begin
          count_a = '0;
          mode_a  = MODE_IDLE;
        end
      end
      MODE_PREPPING: begin
        flute = 1'b1;
        back  = 1'b1;
      end
      default: begin
        flute = in_data.proximity;
        if (in_data.proximity) mode_a = MODE_CARRYING;
      end
    endcase

    if (!in_data.drive_enabled) begin
      flute = 1'b1;
      back  = 1'b0;
    end else if (release_forced) begin
      back = 1'b0;
    end

    count_b        = count_a;
    item_flag_next = in_data.proximity;
    if (!in_data.proximity && item_flag) begin
      count_b        = count_up(count_a);
      item_flag_next = 1'b1;
      if (count_b > {1'b0, release_ticks}) begin
        item_flag_next = 1'b0;
        count_b        = '0;
      end
    end

    mode_next       = mode_a;
    tick_count_next = count_b;
    if (in_data.kind == KIND_GOAL) begin
      item_flag_next  = item_flag;
      tick_count_next = tick_count;
      case (in_data.goal_code)
        GOAL_INTAKE:  mode_next = MODE_INTAKING;
        GOAL_HOLD:    mode_next = MODE_CARRYING;
        GOAL_SCORE: begin
          mode_next       = MODE_OUTTAKING;
          tick_count_next = '0;
        end
        GOAL_PREP:    mode_next = MODE_PREPPING;
        GOAL_HANDOFF: mode_next = MODE_HANDOFF;
        default:      mode_next = mode;
      endcase
    end

    result.flute_out     = flute;
    result.backplate_out = back;
    result.holding_item  = item_flag_next;
    result.mode_code     = mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      score_ticks   <= SCORE_TICKS_RESET;
      release_ticks <= RELEASE_TICKS_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SCORE_TICKS) score_ticks <= cfg_data;
      else release_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      tick_count     <= '0;
      item_flag      <= 1'b0;
      release_forced <= 1'b0;
    end else if (take) begin
      mode       <= mode_next;
      tick_count <= tick_count_next;
      item_flag  <= item_flag_next;
      if (in_data.kind == KIND_GOAL) release_forced <= in_data.force_release;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
        out_data  <= result;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_data  <= result;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("Buffered result present while the output register is empty.");

  a_tick_gives_result: assert property (@(posedge clk) disable iff (rst)
    (push && !out_valid) |=> out_valid)
    else $error("Tick transfer into an empty buffer gave no result.");

  a_flag_drop_needs_clear: assert property (@(posedge clk) disable iff (rst)
    $fell(item_flag) |-> $past(push && !in_data.proximity))
    else $error("Has-item flag dropped without a tick with the sensor clear.");

endmodule
